// File: src/pcmf_pkg.sv
// Shared constants, control word and flag types for the Potts flip block.
`timescale 1ns / 1ps

package pcmf_pkg;

  localparam int SITES_DEF = 1024;
  localparam int COLOURS = 4;
  localparam int CLR_W = 2;
  localparam int SITE_W = 10;
  localparam int Q_W = 16;
  localparam int CNT_OUT_W = 11;
  localparam logic [Q_W-1:0] DECAY_RESET = 16'd32768;

  localparam logic OP_PROPOSE = 1'b0;
  localparam logic OP_FILL = 1'b1;

  typedef enum logic [4:0] {
    S_CLR_INIT  = 5'd0,
    S_CLR_LOOP  = 5'd1,
    S_CLR_END   = 5'd2,
    S_RESULT    = 5'd3,
    S_IDLE      = 5'd4,
    S_DISPATCH  = 5'd5,
    S_CHECK     = 5'd6,
    S_SAME_CHK  = 5'd7,
    S_KTEST     = 5'd8,
    S_MUL       = 5'd9,
    S_SQR       = 5'd10,
    S_DECIDE    = 5'd11,
    S_COMMIT_A  = 5'd12,
    S_COMMIT_B  = 5'd13,
    S_ACC_SAME  = 5'd14,
    S_FILL_INIT = 5'd15,
    S_FILL_LOOP = 5'd16,
    S_FILL_END  = 5'd17
  } step_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_SWEEP_INIT,
    A_SWEEP_WR,
    A_RESULT,
    A_TAKE,
    A_RD_CNT_NEW,
    A_RD_CNT_OLD,
    A_POW_INIT,
    A_MUL,
    A_POW_STEP,
    A_COMMIT_A,
    A_COMMIT_B,
    A_SET_ACC,
    A_FILL_COUNTS
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_FILL,
    C_SITE_BAD,
    C_SAME,
    C_NOT_NEG,
    C_E_MORE,
    C_REJECT,
    C_SWEEP_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t act;
  } ctl_t;

  typedef struct packed {
    logic no_in;
    logic fill;
    logic site_bad;
    logic same;
    logic not_neg;
    logic e_more;
    logic reject;
    logic sweep_more;
    logic out_busy;
  } flags_t;

endpackage

// File: src/pcmf_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module pcmf_seq (
  input  logic            clk,
  input  logic            rst,
  input  pcmf_pkg::flags_t flags,
  output pcmf_pkg::ctl_t  ctl
);
  import pcmf_pkg::*;

  step_t step;
  step_t step_next;
  step_t target;
  cond_t cond;
  act_t  act;
  logic  jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLR_INIT;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    act = A_NOP;
    cond = C_NEVER;
    target = S_IDLE;
    unique case (step)
      S_CLR_INIT: begin
        act = A_SWEEP_INIT;
      end
      S_CLR_LOOP: begin
        act = A_SWEEP_WR;
        cond = C_SWEEP_MORE;
        target = S_CLR_LOOP;
      end
      S_CLR_END: begin
        cond = C_ALWAYS;
        target = S_IDLE;
      end
      S_RESULT: begin
        act = A_RESULT;
        cond = C_OUT_BUSY;
        target = S_RESULT;
      end
      S_IDLE: begin
        act = A_TAKE;
        cond = C_NO_IN;
        target = S_IDLE;
      end
      S_DISPATCH: begin
        act = A_RD_CNT_NEW;
        cond = C_FILL;
        target = S_FILL_INIT;
      end
      S_CHECK: begin
        act = A_RD_CNT_OLD;
        cond = C_SITE_BAD;
        target = S_RESULT;
      end
      S_SAME_CHK: begin
        cond = C_SAME;
        target = S_ACC_SAME;
      end
      S_KTEST: begin
        act = A_POW_INIT;
        cond = C_NOT_NEG;
        target = S_COMMIT_A;
      end
      S_MUL: begin
        act = A_MUL;
      end
      S_SQR: begin
        act = A_POW_STEP;
        cond = C_E_MORE;
        target = S_MUL;
      end
      S_DECIDE: begin
        cond = C_REJECT;
        target = S_RESULT;
      end
      S_COMMIT_A: begin
        act = A_COMMIT_A;
      end
      S_COMMIT_B: begin
        act = A_COMMIT_B;
        cond = C_ALWAYS;
        target = S_RESULT;
      end
      S_ACC_SAME: begin
        act = A_SET_ACC;
        cond = C_ALWAYS;
        target = S_RESULT;
      end
      S_FILL_INIT: begin
        act = A_SWEEP_INIT;
      end
      S_FILL_LOOP: begin
        act = A_SWEEP_WR;
        cond = C_SWEEP_MORE;
        target = S_FILL_LOOP;
      end
      S_FILL_END: begin
        act = A_FILL_COUNTS;
        cond = C_ALWAYS;
        target = S_RESULT;
      end
      default: begin
        cond = C_ALWAYS;
        target = S_CLR_INIT;
      end
    endcase
  end

  always_comb begin
    unique case (cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_IN:      jump = flags.no_in;
      C_FILL:       jump = flags.fill;
      C_SITE_BAD:   jump = flags.site_bad;
      C_SAME:       jump = flags.same;
      C_NOT_NEG:    jump = flags.not_neg;
      C_E_MORE:     jump = flags.e_more;
      C_REJECT:     jump = flags.reject;
      C_SWEEP_MORE: jump = flags.sweep_more;
      C_OUT_BUSY:   jump = flags.out_busy;
      default:      jump = 1'b0;
    endcase
    step_next = jump ? target : step_t'(step + 5'd1);
  end

  assign ctl.act = act;

endmodule

// File: src/pcmf_dpath.sv
// Datapath: site memory, colour counts, power unit and item registers.
`timescale 1ns / 1ps

module pcmf_dpath #(
  parameter int SITES = pcmf_pkg::SITES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcmf_pkg::ctl_t                ctl,
  output pcmf_pkg::flags_t              flags,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [pcmf_pkg::SITE_W-1:0]   site,
  input  logic [pcmf_pkg::CLR_W-1:0]    colour,
  input  logic [pcmf_pkg::Q_W-1:0]      uniform,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcmf_pkg::Q_W-1:0]      decay_per_edge,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [pcmf_pkg::CLR_W-1:0]    site_colour,
  output logic [pcmf_pkg::CNT_OUT_W-1:0] colour_count
);
  import pcmf_pkg::*;

  localparam int ADDR_W = $clog2(SITES);
  localparam int CNT_W = $clog2(SITES + 1);

  logic [Q_W-1:0]     decay;
  logic               op_r;
  logic [SITE_W-1:0]  site_r;
  logic [CLR_W-1:0]   colour_r;
  logic [Q_W-1:0]     uniform_r;

  logic [CLR_W-1:0]   mem [SITES];
  logic [CLR_W-1:0]   rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  site_addr;
  logic [ADDR_W+SITE_W-1:0] site_wide;
  logic [ADDR_W-1:0]  sweep;

  logic [CNT_W-1:0]   counts [COLOURS];
  logic [CLR_W-1:0]   cnt_raddr;
  logic [CNT_W-1:0]   cnt_rd;
  logic [CNT_W-1:0]   cnt_new;
  logic [CNT_W-1:0]   cnt_old;
  logic [CNT_W:0]     cnt_new_inc;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  logic [CLR_W-1:0]   old_r;
  logic               acc_r;
  logic               site_ok;
  logic               out_load;

  logic [CNT_W-1:0]   e_r;
  logic [Q_W:0]       r_r;
  logic [Q_W-1:0]     b_r;
  logic [2*Q_W:0]     pr;
  logic [2*Q_W-1:0]   pb;

  assign in_ready = (ctl.act == A_TAKE);
  assign cfg_ready = 1'b1;

  assign site_wide = {{ADDR_W{1'b0}}, site_r};
  assign site_addr = site_wide[ADDR_W-1:0];
  assign site_ok = (32'(site_r) < SITES);

  assign cnt_new_inc = {1'b0, cnt_new} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    flags.no_in = !in_valid;
    flags.fill = (op_r == OP_FILL);
    flags.site_bad = !site_ok;
    flags.same = (old_r == colour_r);
    flags.not_neg = !(cnt_new_inc < {1'b0, cnt_old});
    flags.e_more = |e_r[CNT_W-1:1];
    flags.reject = ({1'b0, uniform_r} > r_r);
    flags.sweep_more = (sweep != ADDR_W'(SITES - 1));
    flags.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decay <= DECAY_RESET;
    end else if (cfg_valid) begin
      decay <= decay_per_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_r <= '0;
    end else if (in_ready && in_valid) begin
      colour_r <= colour;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r <= op;
      site_r <= site;
      uniform_r <= uniform;
    end
  end

  assign mem_we = (ctl.act == A_SWEEP_WR) || (ctl.act == A_COMMIT_A);
  assign mem_waddr = (ctl.act == A_SWEEP_WR) ? sweep : site_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= colour_r;
    end
    rdata <= mem[site_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.act == A_SWEEP_INIT) begin
      sweep <= '0;
    end else if (ctl.act == A_SWEEP_WR) begin
      sweep <= sweep + 1'b1;
    end
  end

  always_comb begin
    case (ctl.act)
      A_RD_CNT_OLD: cnt_raddr = rdata;
      A_COMMIT_A:   cnt_raddr = old_r;
      default:      cnt_raddr = colour_r;
    endcase
  end
  assign cnt_rd = counts[cnt_raddr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLOURS; i++) begin
        counts[i] <= (i == 0) ? CNT_W'(SITES) : '0;
      end
    end else begin
      case (ctl.act)
        A_FILL_COUNTS: begin
          for (int i = 0; i < COLOURS; i++) begin
            counts[i] <= (colour_r == CLR_W'(i)) ? CNT_W'(SITES) : '0;
          end
        end
        A_COMMIT_A: counts[cnt_raddr] <= cnt_rd - 1'b1;
        A_COMMIT_B: counts[cnt_raddr] <= cnt_rd + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.act)
      A_RD_CNT_NEW: cnt_new <= cnt_rd;
      A_RD_CNT_OLD: begin
        cnt_old <= cnt_rd;
        old_r <= rdata;
      end
      A_COMMIT_A:    old_r <= colour_r;
      A_FILL_COUNTS: old_r <= colour_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_r <= 1'b0;
    end else begin
      case (ctl.act)
        A_TAKE: acc_r <= 1'b0;
        A_COMMIT_B, A_SET_ACC, A_FILL_COUNTS: acc_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.act)
      A_POW_INIT: begin
        r_r <= {1'b1, {Q_W{1'b0}}};
        b_r <= decay;
        e_r <= cnt_old - cnt_new - 1'b1;
      end
      A_MUL: begin
        pr <= (2*Q_W+1)'(r_r) * (2*Q_W+1)'(b_r);
        pb <= (2*Q_W)'(b_r) * (2*Q_W)'(b_r);
      end
      A_POW_STEP: begin
        if (e_r[0]) begin
          r_r <= pr[2*Q_W:Q_W];
        end
        b_r <= pb[2*Q_W-1:Q_W];
        e_r <= e_r >> 1;
      end
      default: ;
    endcase
  end

  assign out_load = (ctl.act == A_RESULT) && !(out_valid && !out_ready);
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, cnt_rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted <= acc_r;
      site_colour <= site_ok ? old_r : '0;
      colour_count <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

endmodule

// File: src/potts_complete_graph_metropolis_flip.sv
// Top level of the Potts-model Metropolis single-site flip block.
// Input channel (in_valid/in_ready) takes one item: op, site, colour, uniform.
// op propose tests a colour change of one site; op fill sets every site.
// Output channel (out_valid/out_ready) gives one item per input item:
// accepted, site_colour and colour_count after the step.
// Config channel (cfg_valid/cfg_ready) loads decay_per_edge; write it idle.
// A microcoded sequencer steps a datapath with one site memory and a 17x16
// and a 16x16 multiply; the power loop does a multiply and a square per bit.
// Proposal: an unchanged colour is accepted without a write, a flip that
// needs no power commits at once, and else the power loop runs over the
// exponent bits before the decision; a reject skips the two commit steps.
// Fill sweeps every site, then sets the counts. The result item goes valid
// in the cycle in which in_ready returns.
// Reset: clears the sequencer, puts every site in the colour 0 count,
// then sweeps the site memory to colour 0 before in_ready first rises.
// A stalled receiver holds the result register; the block still takes the
// next item and works it up to its result step, then waits there.
`timescale 1ns / 1ps

module potts_complete_graph_metropolis_flip #(
  parameter int SITES = pcmf_pkg::SITES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [pcmf_pkg::SITE_W-1:0]    site,
  input  logic [pcmf_pkg::CLR_W-1:0]     colour,
  input  logic [pcmf_pkg::Q_W-1:0]       uniform,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcmf_pkg::Q_W-1:0]       decay_per_edge,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic [pcmf_pkg::CLR_W-1:0]     site_colour,
  output logic [pcmf_pkg::CNT_OUT_W-1:0] colour_count
);
  import pcmf_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  pcmf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  pcmf_dpath #(
    .SITES (SITES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .flags          (flags),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .site           (site),
    .colour         (colour),
    .uniform        (uniform),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .decay_per_edge (decay_per_edge),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .site_colour    (site_colour),
    .colour_count   (colour_count)
  );

endmodule
